/* sv/hvbr_pkg.sv */
`default_nettype none

package hvbr_pkg;

	localparam int unsigned PLANE_BYTES   = 16384;
	localparam int unsigned LINE_TSTATES  = 224;
	localparam int unsigned SHOWN_LINES   = 288;

	localparam int unsigned BLANK_LINES = 24;
	localparam int unsigned PAPER_T0    = 24;
	localparam int unsigned PAPER_TN    = 128;
	localparam int unsigned PAPER_T1    = PAPER_T0 + PAPER_TN;
	localparam int unsigned VIS_T_END   = PAPER_T1 + 24;
	localparam int unsigned PAPER_ROWS  = 240;

	localparam int unsigned VRAM_DEPTH = 2 * PLANE_BYTES;
	localparam int unsigned VRAM_AW    = $clog2(VRAM_DEPTH);
	localparam int unsigned OFF_W      = $clog2(PLANE_BYTES);
	localparam int unsigned PAL_DEPTH  = 16;
	localparam int unsigned PAL_AW     = $clog2(PAL_DEPTH);

	localparam int unsigned TS_W   = 17;
	localparam int unsigned LINE_W = 10;
	localparam int unsigned TL_W   = 8;
	localparam int unsigned ROW_W  = 9;
	localparam int unsigned COL_W  = 10;
	localparam int unsigned CNT_W  = 3;
	localparam int unsigned PIX_W  = 24;
	localparam int unsigned XB_W   = 12;
	localparam int unsigned PT_W   = 7;

	localparam int unsigned DIV_SHIFT   = 25;
	localparam int unsigned DIV_RECIP   = ((1 << DIV_SHIFT) + LINE_TSTATES - 1) / LINE_TSTATES;
	localparam int unsigned DIV_RECIP_W = $clog2(DIV_RECIP + 1);
	localparam int unsigned DIV_PROD_W  = TS_W + DIV_RECIP_W;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_VWRITE = 2'd1,
		REQ_PWRITE = 2'd2
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_TOP   = 3'd0,
		CFG_SCREEN_LEFT  = 3'd1,
		CFG_SCREEN_WIDTH = 3'd2,
		CFG_FRAME_WIDTH  = 3'd3,
		CFG_MONOCHROME   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_BORDER,
		OP_PAPER,
		OP_PALWR
	} op_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [TS_W-1:0]  tstate;
		logic [2:0]       border_color;
		logic             shadow_bank;
		logic [2:0]       port_fe_low;
		logic [1:0]       write_target;
		logic [OFF_W-1:0] write_offset;
		logic [7:0]       write_data;
		logic [3:0]       palette_index;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] x_start;
		logic [CNT_W-1:0] pixel_count;
		logic [PIX_W-1:0] pixel0;
		logic [PIX_W-1:0] pixel1;
		logic [PIX_W-1:0] pixel2;
		logic [PIX_W-1:0] pixel3;
	} pix_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_t;

	function automatic logic [7:0] scale7(input logic [2:0] v);
		logic [7:0] s;
		case (v)
			3'd0:    s = 8'd0;
			3'd1:    s = 8'd36;
			3'd2:    s = 8'd72;
			3'd3:    s = 8'd109;
			3'd4:    s = 8'd145;
			3'd5:    s = 8'd182;
			3'd6:    s = 8'd218;
			default: s = 8'd255;
		endcase
		return s;
	endfunction

	// GGGRRRBB to blue, green, red bytes
	function automatic logic [PIX_W-1:0] pal_rgb(input logic [7:0] raw);
		logic [7:0] b;
		b = {raw[1:0], raw[1:0], raw[1:0], raw[1:0]};
		return {b, scale7(raw[7:5]), scale7(raw[4:2])};
	endfunction

endpackage

`default_nettype wire

/* sv/hvbr_req_if.sv */
`default_nettype none

interface hvbr_req_if;
	logic            valid;
	logic            ready;
	hvbr_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input ready, input data);
endinterface

`default_nettype wire

/* sv/hvbr_pix_if.sv */
`default_nettype none

interface hvbr_pix_if;
	logic            valid;
	logic            ready;
	hvbr_pkg::pix_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input ready, input data);
endinterface

`default_nettype wire

/* sv/hvbr_cfg_if.sv */
`default_nettype none

interface hvbr_cfg_if;
	logic            valid;
	logic            ready;
	hvbr_pkg::cfg_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input ready, input data);
endinterface

`default_nettype wire

/* sv/hires_video_beam_renderer.sv */
// channel | dir | transfer when          | carries
// req     | in  | req.valid & req.ready  | tick, video memory write or palette write
// pix     | out | pix.valid & pix.ready  | row, x_start, pixel_count, four BGR pixels
// cfg     | in  | cfg.valid & cfg.ready  | register index and write data
//
// Three stages, one item per cycle while pix.ready holds and no sweep runs; an item passes
// the stage 1, 2 and 3 registers in order, and its result is offered from stage 3.
// Stage 1 splits the T-state and reads video memory, stage 2 reads the two palette copies.
// After reset the video memories are swept to zero, all 32768 addresses, with req.ready low;
// cfg is taken throughout.
// A stalled result holds; empty stages fill, so req keeps moving until all three are full.
`default_nettype none

module hires_video_beam_renderer #(
	parameter int unsigned LINE_TSTATES = hvbr_pkg::LINE_TSTATES,
	parameter int unsigned SHOWN_LINES  = hvbr_pkg::SHOWN_LINES
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hvbr_req_if.sink    req,
	hvbr_pix_if.source  pix,
	hvbr_cfg_if.sink    cfg
);

	localparam int unsigned DIV_RECIP =
		((1 << hvbr_pkg::DIV_SHIFT) + LINE_TSTATES - 1) / LINE_TSTATES;

	logic [5:0]                    top_q;
	logic [hvbr_pkg::COL_W-1:0]    left_q;
	logic [hvbr_pkg::COL_W-1:0]    width_q;
	logic [hvbr_pkg::COL_W-1:0]    fw_q;
	logic                          mono_q;

	logic                          clr_busy_q;
	logic [hvbr_pkg::VRAM_AW-1:0]  clr_addr_q;

	logic                          en1, en2, en3, acc;
	logic                          v1_s1, v2_s2, v3_s3;

	logic [hvbr_pkg::DIV_PROD_W-1:0] prod;
	hvbr_pkg::req_t                  req_s1;
	logic [hvbr_pkg::LINE_W-1:0]     line_s1;

	// stage 1
	logic [hvbr_pkg::TL_W-1:0]     tl;
	logic [hvbr_pkg::ROW_W-1:0]    row1;
	logic                          vis, paper_row, paper_t, is_tick, is_paper, emit_b, keep1;
	logic [hvbr_pkg::PT_W-1:0]     t_rel;
	logic [7:0]                    vrow;
	logic [hvbr_pkg::OFF_W-1:0]    off;
	logic [hvbr_pkg::VRAM_AW-1:0]  rd_addr;
	logic [hvbr_pkg::XB_W-1:0]     xb, rem;
	logic [hvbr_pkg::CNT_W-1:0]    cnt_raw, cnt_b, cnt1;
	logic [hvbr_pkg::COL_W-1:0]    x1;
	hvbr_pkg::op_t                 op1;
	logic                          vwr;
	logic [hvbr_pkg::VRAM_AW-1:0]  wr_addr;
	logic                          bm_we, at_we;

	hvbr_pkg::op_t                 op_s2;
	logic [hvbr_pkg::ROW_W-1:0]    row_s2;
	logic [hvbr_pkg::COL_W-1:0]    x_s2;
	logic [hvbr_pkg::CNT_W-1:0]    cnt_s2;
	logic                          half_s2;
	logic [2:0]                    bord_s2;
	logic [2:0]                    pfe_s2;
	logic [hvbr_pkg::PAL_AW-1:0]   pidx_s2;
	logic [7:0]                    wdat_s2;
	logic [7:0]                    bm_rd, at_rd;

	// stage 2
	logic [7:0]                    attr;
	logic [hvbr_pkg::PAL_AW-1:0]   ink_idx, pap_idx;
	logic [3:0]                    nib;
	logic                          pal_we;
	logic [hvbr_pkg::PAL_DEPTH-1:0] pal_vld_q;

	logic [hvbr_pkg::ROW_W-1:0]    row_s3;
	logic [hvbr_pkg::COL_W-1:0]    x_s3;
	logic [hvbr_pkg::CNT_W-1:0]    cnt_s3;
	logic                          paper_s3;
	logic [3:0]                    nib_s3;
	logic                          ink_vld_s3, pap_vld_s3;
	logic [7:0]                    ink_rd, pap_rd;

	logic [hvbr_pkg::PIX_W-1:0]    ink_rgb, pap_rgb;
	logic [hvbr_pkg::PIX_W-1:0]    pv [4];

	assign en3 = !v3_s3 || pix.ready;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign req.ready = en1 && !clr_busy_q;
	assign acc = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= 6'd24;
			left_q  <= hvbr_pkg::COL_W'(48);
			width_q <= hvbr_pkg::COL_W'(512);
			fw_q    <= hvbr_pkg::COL_W'(608);
			mono_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.data.idx)
				hvbr_pkg::CFG_SCREEN_TOP:   top_q   <= cfg.data.wdata[5:0];
				hvbr_pkg::CFG_SCREEN_LEFT:  left_q  <= cfg.data.wdata;
				hvbr_pkg::CFG_SCREEN_WIDTH: width_q <= cfg.data.wdata;
				hvbr_pkg::CFG_FRAME_WIDTH:  fw_q    <= cfg.data.wdata;
				hvbr_pkg::CFG_MONOCHROME:   mono_q  <= cfg.data.wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// line by reciprocal multiply
	assign prod = hvbr_pkg::DIV_PROD_W'(req.data.tstate)
		* hvbr_pkg::DIV_PROD_W'(DIV_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1  <= req.data;
			line_s1 <= prod[hvbr_pkg::DIV_SHIFT +: hvbr_pkg::LINE_W];
		end
	end

	always_comb begin
		tl = hvbr_pkg::TL_W'(req_s1.tstate
			- hvbr_pkg::TS_W'(line_s1 * LINE_TSTATES));
		vis = (line_s1 >= hvbr_pkg::LINE_W'(hvbr_pkg::BLANK_LINES))
			&& (line_s1 < hvbr_pkg::LINE_W'(hvbr_pkg::BLANK_LINES + SHOWN_LINES))
			&& (tl < hvbr_pkg::TL_W'(hvbr_pkg::VIS_T_END));
		row1 = hvbr_pkg::ROW_W'(line_s1 - hvbr_pkg::LINE_W'(hvbr_pkg::BLANK_LINES));
		paper_row = (row1 >= hvbr_pkg::ROW_W'(top_q))
			&& (row1 < hvbr_pkg::ROW_W'(top_q) + hvbr_pkg::ROW_W'(hvbr_pkg::PAPER_ROWS));
		paper_t = (tl >= hvbr_pkg::TL_W'(hvbr_pkg::PAPER_T0))
			&& (tl < hvbr_pkg::TL_W'(hvbr_pkg::PAPER_T1));
		is_tick = req_s1.req_type == hvbr_pkg::REQ_TICK;
		is_paper = is_tick && vis && paper_row && paper_t;

		t_rel = hvbr_pkg::PT_W'(tl - hvbr_pkg::TL_W'(hvbr_pkg::PAPER_T0));
		vrow = 8'(row1 - hvbr_pkg::ROW_W'(top_q));
		// interleaved line address; first byte of a cell sits in the upper half
		off = {~t_rel[1], vrow[7:6], vrow[2:0], vrow[5:3], t_rel[6:2]};
		rd_addr = {req_s1.shadow_bank, off};

		if (tl < hvbr_pkg::TL_W'(hvbr_pkg::PAPER_T0)) begin
			xb = hvbr_pkg::XB_W'({tl, 1'b0});
			cnt_raw = 3'd2;
		end else if (tl >= hvbr_pkg::TL_W'(hvbr_pkg::PAPER_T1)) begin
			xb = hvbr_pkg::XB_W'(left_q) + hvbr_pkg::XB_W'(width_q)
				+ hvbr_pkg::XB_W'({tl - hvbr_pkg::TL_W'(hvbr_pkg::PAPER_T1), 1'b0});
			cnt_raw = 3'd2;
		end else begin
			xb = hvbr_pkg::XB_W'(left_q) + hvbr_pkg::XB_W'({t_rel, 2'b00});
			cnt_raw = 3'd4;
		end
		rem = hvbr_pkg::XB_W'(fw_q) - xb;
		cnt_b = (rem < hvbr_pkg::XB_W'(cnt_raw)) ? rem[hvbr_pkg::CNT_W-1:0] : cnt_raw;
		emit_b = is_tick && vis && !is_paper && (xb < hvbr_pkg::XB_W'(fw_q));

		x1 = is_paper ? hvbr_pkg::COL_W'(left_q + {t_rel, 2'b00}) : xb[hvbr_pkg::COL_W-1:0];
		cnt1 = is_paper ? 3'd4 : cnt_b;

		if (req_s1.req_type == hvbr_pkg::REQ_PWRITE) begin
			op1 = hvbr_pkg::OP_PALWR;
		end else if (is_paper) begin
			op1 = hvbr_pkg::OP_PAPER;
		end else begin
			op1 = hvbr_pkg::OP_BORDER;
		end
		keep1 = is_paper || emit_b || (req_s1.req_type == hvbr_pkg::REQ_PWRITE);

		vwr = v1_s1 && en2 && (req_s1.req_type == hvbr_pkg::REQ_VWRITE);
		wr_addr = clr_busy_q ? clr_addr_q : {req_s1.write_target[0], req_s1.write_offset};
		bm_we = clr_busy_q || (vwr && !req_s1.write_target[1]);
		at_we = clr_busy_q || (vwr && req_s1.write_target[1]);
	end

	hvbr_ram #(
		.WIDTH (8),
		.DEPTH (hvbr_pkg::VRAM_DEPTH)
	) u_bitmap_ram (
		.clk   (clk),
		.we    (bm_we),
		.waddr (wr_addr),
		.wdata (clr_busy_q ? 8'd0 : req_s1.write_data),
		.re    (v1_s1 && en2),
		.raddr (rd_addr),
		.rdata (bm_rd)
	);

	hvbr_ram #(
		.WIDTH (8),
		.DEPTH (hvbr_pkg::VRAM_DEPTH)
	) u_attr_ram (
		.clk   (clk),
		.we    (at_we),
		.waddr (wr_addr),
		.wdata (clr_busy_q ? 8'd0 : req_s1.write_data),
		.re    (v1_s1 && en2),
		.raddr (rd_addr),
		.rdata (at_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1 && keep1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2   <= op1;
			row_s2  <= row1;
			x_s2    <= x1;
			cnt_s2  <= cnt1;
			half_s2 <= t_rel[0];
			bord_s2 <= ~req_s1.border_color;
			pfe_s2  <= req_s1.port_fe_low;
			pidx_s2 <= req_s1.palette_index;
			wdat_s2 <= req_s1.write_data;
		end
	end

	always_comb begin
		attr = mono_q ? {2'b00, pfe_s2 ^ 3'b111, pfe_s2} : at_rd;
		ink_idx = {attr[6], attr[2:0]};
		pap_idx = (op_s2 == hvbr_pkg::OP_PAPER) ? {attr[7], attr[5:3]} : {1'b0, bord_s2};
		nib = half_s2 ? bm_rd[3:0] : bm_rd[7:4];
		pal_we = v2_s2 && en3 && (op_s2 == hvbr_pkg::OP_PALWR);
	end

	hvbr_ram #(
		.WIDTH (8),
		.DEPTH (hvbr_pkg::PAL_DEPTH)
	) u_pal_ink_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pidx_s2),
		.wdata (wdat_s2),
		.re    (v2_s2 && en3),
		.raddr (ink_idx),
		.rdata (ink_rd)
	);

	hvbr_ram #(
		.WIDTH (8),
		.DEPTH (hvbr_pkg::PAL_DEPTH)
	) u_pal_pap_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pidx_s2),
		.wdata (wdat_s2),
		.re    (v2_s2 && en3),
		.raddr (pap_idx),
		.rdata (pap_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (pal_we) begin
			pal_vld_q[pidx_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2 && (op_s2 != hvbr_pkg::OP_PALWR);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			row_s3     <= row_s2;
			x_s3       <= x_s2;
			cnt_s3     <= cnt_s2;
			paper_s3   <= op_s2 == hvbr_pkg::OP_PAPER;
			nib_s3     <= nib;
			ink_vld_s3 <= pal_vld_q[ink_idx];
			pap_vld_s3 <= pal_vld_q[pap_idx];
		end
	end

	always_comb begin
		ink_rgb = hvbr_pkg::pal_rgb(ink_vld_s3 ? ink_rd : 8'd0);
		pap_rgb = hvbr_pkg::pal_rgb(pap_vld_s3 ? pap_rd : 8'd0);
		for (int k = 0; k < 4; k++) begin
			if (paper_s3) begin
				pv[k] = nib_s3[3-k] ? ink_rgb : pap_rgb;
			end else begin
				pv[k] = (hvbr_pkg::CNT_W'(k) < cnt_s3) ? pap_rgb : '0;
			end
		end
	end

	assign pix.valid            = v3_s3;
	assign pix.data.row         = row_s3;
	assign pix.data.x_start     = x_s3;
	assign pix.data.pixel_count = cnt_s3;
	assign pix.data.pixel0      = pv[0];
	assign pix.data.pixel1      = pv[1];
	assign pix.data.pixel2      = pv[2];
	assign pix.data.pixel3      = pv[3];

endmodule

`default_nettype wire

/* sv/hvbr_ram.sv */
`default_nettype none

module hvbr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/hvbr_checker.sv */
`default_nettype none

module hvbr_checker #(
	parameter int unsigned SHOWN_LINES = hvbr_pkg::SHOWN_LINES
) (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            pix_valid,
	input wire logic            pix_ready,
	input wire hvbr_pkg::pix_t  pix_data
);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (pix_data.pixel_count >= 3'd1) && (pix_data.pixel_count <= 3'd4))
		else $error("pixel_count out of range");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> ((pix_data.pixel_count >= 3'd4) || (pix_data.pixel3 == '0))
			&& ((pix_data.pixel_count >= 3'd3) || (pix_data.pixel2 == '0))
			&& ((pix_data.pixel_count >= 3'd2) || (pix_data.pixel1 == '0)))
		else $error("pixel beyond pixel_count not zero");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pix_data.row < hvbr_pkg::ROW_W'(SHOWN_LINES))
		else $error("row beyond visible lines");

	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix_data))
		else $error("stalled result changed");

endmodule

bind hires_video_beam_renderer hvbr_checker #(
	.SHOWN_LINES (SHOWN_LINES)
) u_hvbr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.pix_data  (pix.data)
);

`default_nettype wire
